FILE: hdl/ami_pkg.sv
// shared constants and types of the affine matrix inverse
`timescale 1ns / 1ps
package ami_pkg;
	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS = 16;
	localparam int THR_WIDTH = 31;

	localparam int CW = 2 * DATA_WIDTH + 1;
	localparam int PW = 2 * DATA_WIDTH;
	localparam int LW = 2 * DATA_WIDTH + 1;
	localparam int PRW = 3 * DATA_WIDTH + 2;
	localparam int DETW = 3 * DATA_WIDTH + 4;
	localparam int QB = DATA_WIDTH + 3;
	localparam int NW = DETW + FRAC_BITS;
	localparam int RW = DETW;
	localparam int DIV_LAT = QB + 2;
	localparam int NCOF = 9;
	localparam int NELEM = 12;
	localparam int NPROD = 12;
	localparam int NLANE = 4;

	typedef logic [1:0] row_t;
	localparam row_t ROW0 = 2'd0;
	localparam row_t ROW1 = 2'd1;
	localparam row_t ROW2 = 2'd2;
	localparam row_t ROW_LAST = ROW2;

	typedef logic signed [DATA_WIDTH-1:0] data_t;

	localparam data_t FIX_ONE = data_t'(64'd1 << FRAC_BITS);
	localparam data_t FIX_ZERO = data_t'(0);

	typedef struct packed {
		logic                      valid;
		logic                      singular;
		logic                      det_neg;
		logic [DETW-1:0]           det_abs;
		logic [NCOF-1:0][CW-1:0]   cof;
		logic [2:0][DETW-1:0]      num;
	} front_t;

	typedef struct packed {
		logic valid;
		row_t row;
		logic singular;
	} meta_t;
endpackage

FILE: hdl/ami_if.sv
// channel interfaces: matrix in, inverse row out, threshold write
`timescale 1ns / 1ps
interface ami_mat_if;
	import ami_pkg::*;
	logic  valid;
	logic  ready;
	data_t m00, m01, m02, m10, m11, m12, m20, m21, m22, tx, ty, tz;
	modport source(output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, tx, ty, tz,
		input ready);
	modport sink(input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, tx, ty, tz,
		output ready);
endinterface

interface ami_out_if;
	import ami_pkg::*;
	logic  valid;
	logic  ready;
	row_t  row_index;
	data_t inv_c0, inv_c1, inv_c2, inv_c3;
	logic  singular;
	logic  saturated;
	logic  last_row;
	modport source(output valid, row_index, inv_c0, inv_c1, inv_c2, inv_c3, singular,
		saturated, last_row, input ready);
	modport sink(input valid, row_index, inv_c0, inv_c1, inv_c2, inv_c3, singular,
		saturated, last_row, output ready);
endinterface

interface ami_cfg_if;
	import ami_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [THR_WIDTH-1:0] singular_threshold;
	modport source(output valid, singular_threshold, input ready);
	modport sink(input valid, singular_threshold, output ready);
endinterface

FILE: hdl/ami_front.sv
// matrix-wide pipeline: cofactors, determinant, translation numerators, singular test
`timescale 1ns / 1ps
module ami_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  ami_pkg::data_t                a [ami_pkg::NELEM],
	input  logic [ami_pkg::THR_WIDTH-1:0] thr,
	output ami_pkg::front_t               res
);
	import ami_pkg::*;

	// cofactor operand indices: cof = a[PL]*a[PR] - a[QL]*a[QR]
	localparam int unsigned PL [NCOF] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
	localparam int unsigned PR [NCOF] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
	localparam int unsigned QL [NCOF] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
	localparam int unsigned QR [NCOF] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};
	// wide products: det terms then translation terms
	localparam int unsigned XI [NPROD] = '{0, 1, 2, 9, 10, 11, 9, 10, 11, 9, 10, 11};
	localparam int unsigned CI [NPROD] = '{0, 3, 6, 0, 1, 2, 3, 4, 5, 6, 7, 8};

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;

	data_t                 a_s1 [NELEM];
	logic signed [PW-1:0]  pp_s2 [NCOF];
	logic signed [PW-1:0]  pq_s2 [NCOF];
	data_t                 a_s2 [NELEM];
	logic signed [CW-1:0]  cof_s3 [NCOF];
	data_t                 a_s3 [NELEM];
	logic signed [LW-1:0]  lo_s4 [NPROD];
	logic signed [LW-1:0]  hi_s4 [NPROD];
	logic signed [CW-1:0]  cof_s4 [NCOF];
	logic signed [PRW-1:0] prod_s5 [NPROD];
	logic signed [CW-1:0]  cof_s5 [NCOF];
	logic signed [DETW-1:0] det_s6;
	logic signed [DETW-1:0] num_s6 [3];
	logic signed [CW-1:0]  cof_s6 [NCOF];
	logic                  sing_s7;
	logic                  dneg_s7;
	logic [DETW-1:0]       dabs_s7;
	logic [NCOF-1:0][CW-1:0] cof_s7;
	logic [2:0][DETW-1:0]  num_s7;

	logic [DETW-1:0] det_abs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	assign det_abs = det_s6[DETW-1] ? DETW'(-det_s6) : DETW'(det_s6);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int e = 0; e < NELEM; e++) begin
				a_s1[e] <= a[e];
				a_s2[e] <= a_s1[e];
				a_s3[e] <= a_s2[e];
			end
			for (int c = 0; c < NCOF; c++) begin
				pp_s2[c] <= a_s1[PL[c]] * a_s1[PR[c]];
				pq_s2[c] <= a_s1[QL[c]] * a_s1[QR[c]];
				cof_s3[c] <= CW'(pp_s2[c]) - CW'(pq_s2[c]);
				cof_s4[c] <= cof_s3[c];
				cof_s5[c] <= cof_s4[c];
				cof_s6[c] <= cof_s5[c];
				cof_s7[c] <= cof_s6[c];
			end
			// 32 x 65 split into two partial products
			for (int k = 0; k < NPROD; k++) begin
				lo_s4[k] <= a_s3[XI[k]] * $signed({1'b0, cof_s3[CI[k]][DATA_WIDTH-1:0]});
				hi_s4[k] <= a_s3[XI[k]] * $signed(cof_s3[CI[k]][CW-1:DATA_WIDTH]);
				prod_s5[k] <= (PRW'(hi_s4[k]) <<< DATA_WIDTH) + PRW'(lo_s4[k]);
			end
			det_s6 <= DETW'(prod_s5[0]) + DETW'(prod_s5[1]) + DETW'(prod_s5[2]);
			for (int i = 0; i < 3; i++) begin
				num_s6[i] <= DETW'(prod_s5[3+3*i]) + DETW'(prod_s5[4+3*i])
					+ DETW'(prod_s5[5+3*i]);
				num_s7[i] <= num_s6[i];
			end
			dneg_s7 <= det_s6[DETW-1];
			dabs_s7 <= det_abs;
			sing_s7 <= (det_abs >> (2 * FRAC_BITS)) <= DETW'(thr);
		end
	end

	always_comb begin
		res.valid    = valid_s7;
		res.singular = sing_s7;
		res.det_neg  = dneg_s7;
		res.det_abs  = dabs_s7;
		res.cof      = cof_s7;
		res.num      = num_s7;
	end
endmodule

FILE: hdl/ami_div.sv
// pipelined rounding divider lane, one quotient bit per stage, saturating result
`timescale 1ns / 1ps
module ami_div (
	input  logic                     clk,
	input  logic                     en,
	input  logic [ami_pkg::NW-1:0]   num2,
	input  logic [ami_pkg::DETW-1:0] den,
	input  logic                     neg,
	output ami_pkg::data_t           quo,
	output logic                     sat
);
	import ami_pkg::*;

	localparam logic [QB-1:0] MAG_POS = QB'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
	localparam logic [QB-1:0] MAG_NEG = QB'(64'd1 << (DATA_WIDTH - 1));
	localparam data_t MAX_VAL = data_t'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
	localparam data_t MIN_VAL = data_t'(64'd1 << (DATA_WIDTH - 1));

	logic [RW-1:0]   rem_s [QB+1];
	logic [QB-1:0]   bits_s [QB+1];
	logic [QB-1:0]   q_s [QB+1];
	logic [DETW-1:0] den_s [QB+1];
	logic            neg_s [QB+1];
	logic            ovf_s [QB+1];
	data_t           quo_s;
	logic            sat_s;

	logic [NW-1:0]   hi_part;
	logic            ovf0;
	logic [RW-1:0]   trial [1:QB];
	logic            ge [1:QB];
	logic [QB:0]     qinc;
	logic [QB-1:0]   qr;
	logic [QB-1:0]   qneg;
	logic            big;

	// quotient at or above 2^QB saturates whatever the low bits
	assign hi_part = num2 >> QB;
	assign ovf0 = hi_part >= NW'(den);

	always_comb begin
		for (int k = 1; k <= QB; k++) begin
			trial[k] = {rem_s[k-1][RW-2:0], bits_s[k-1][QB-1]};
			ge[k] = trial[k] >= den_s[k-1];
		end
	end

	// doubled quotient, then half up
	assign qinc = {1'b0, q_s[QB]} + (QB+1)'(1);
	assign qr = qinc[QB:1];
	assign qneg = ~qr + QB'(1);
	assign big = ovf_s[QB] || (neg_s[QB] ? (qr > MAG_NEG) : (qr > MAG_POS));

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= hi_part[RW-1:0];
			bits_s[0] <= num2[QB-1:0];
			q_s[0]    <= '0;
			den_s[0]  <= den;
			neg_s[0]  <= neg;
			ovf_s[0]  <= ovf0;
			for (int k = 1; k <= QB; k++) begin
				rem_s[k]  <= ge[k] ? (trial[k] - den_s[k-1]) : trial[k];
				bits_s[k] <= bits_s[k-1] << 1;
				q_s[k]    <= {q_s[k-1][QB-2:0], ge[k]};
				den_s[k]  <= den_s[k-1];
				neg_s[k]  <= neg_s[k-1];
				ovf_s[k]  <= ovf_s[k-1];
			end
			sat_s <= big;
			if (big) begin
				quo_s <= neg_s[QB] ? MIN_VAL : MAX_VAL;
			end else begin
				quo_s <= neg_s[QB] ? data_t'(qneg[DATA_WIDTH-1:0]) : data_t'(qr[DATA_WIDTH-1:0]);
			end
		end
	end

	assign quo = quo_s;
	assign sat = sat_s;
endmodule

FILE: hdl/affine_matrix_inverse.sv
// top level of the affine 3x4 matrix inverse
`timescale 1ns / 1ps
// Inverts the upper 3x4 of an affine matrix in signed Q16.16 by cofactors and
// the determinant, and delivers three result words per matrix, rows 0, 1 and 2,
// the last with last_row set. A matrix whose |det| in Q16.16 is at or below
// singular_threshold gives identity rows with singular set. Entries are rounded
// to nearest, ties away from zero, and clipped to the Q16.16 range with
// saturated flagging the row. Rate: one row word per cycle while inv.ready does
// not stall the output, so a new matrix is taken for every three row words; four
// pipelined divider lanes (one per column) produce a full row each such cycle.
module affine_matrix_inverse (
	input  logic         clk,
	input  logic         arst_n,
	ami_cfg_if.sink      cfg,
	ami_mat_if.sink      mat,
	ami_out_if.source    inv
);
	import ami_pkg::*;

	logic [THR_WIDTH-1:0] thr_q;
	data_t                a_in [NELEM];
	front_t               fr;
	logic                 fe, be, exp_take;

	logic                  exp_valid_q;
	row_t                  exp_cnt_q;
	logic                  exp_sing_q;
	logic                  exp_dneg_q;
	logic [DETW-1:0]       exp_dabs_q;
	logic [NCOF-1:0][CW-1:0] exp_cof_q;
	logic [2:0][DETW-1:0]  exp_num_q;

	logic signed [CW-1:0]   csel [3];
	logic signed [DETW-1:0] nsel;
	logic [CW-1:0]          cabs [3];
	logic [DETW-1:0]        nabs;

	meta_t            meta_s8;
	logic [NW-1:0]    num2_s8 [NLANE];
	logic             neg_s8 [NLANE];
	logic [DETW-1:0]  dabs_s8;
	meta_t            meta_s [DIV_LAT];
	data_t            quo [NLANE];
	logic             lsat [NLANE];

	logic             inv_valid_q;
	row_t             inv_row_q;
	data_t            inv_c_q [NLANE];
	logic             inv_sing_q;
	logic             inv_sat_q;
	logic             inv_last_q;
	meta_t            mt;

	// threshold register
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (cfg.valid) begin
			thr_q <= cfg.singular_threshold;
		end
	end

	assign a_in[0]  = mat.m00;
	assign a_in[1]  = mat.m01;
	assign a_in[2]  = mat.m02;
	assign a_in[3]  = mat.m10;
	assign a_in[4]  = mat.m11;
	assign a_in[5]  = mat.m12;
	assign a_in[6]  = mat.m20;
	assign a_in[7]  = mat.m21;
	assign a_in[8]  = mat.m22;
	assign a_in[9]  = mat.tx;
	assign a_in[10] = mat.ty;
	assign a_in[11] = mat.tz;

	assign be = !inv_valid_q || inv.ready;
	assign exp_take = !exp_valid_q || (be && (exp_cnt_q == ROW_LAST));
	assign fe = !fr.valid || exp_take;
	assign mat.ready = fe;

	ami_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (fe),
		.in_valid (mat.valid),
		.a        (a_in),
		.thr      (thr_q),
		.res      (fr)
	);

	// row expander: holds one matrix while its three rows go out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_valid_q <= 1'b0;
			exp_cnt_q   <= ROW0;
		end else if (exp_take) begin
			exp_valid_q <= fr.valid;
			exp_cnt_q   <= ROW0;
		end else if (be) begin
			exp_cnt_q <= exp_cnt_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (exp_take) begin
			exp_sing_q <= fr.singular;
			exp_dneg_q <= fr.det_neg;
			exp_dabs_q <= fr.det_abs;
			exp_cof_q  <= fr.cof;
			exp_num_q  <= fr.num;
		end
	end

	always_comb begin
		unique case (exp_cnt_q)
			ROW0: begin
				csel[0] = exp_cof_q[0];
				csel[1] = exp_cof_q[1];
				csel[2] = exp_cof_q[2];
				nsel    = exp_num_q[0];
			end
			ROW1: begin
				csel[0] = exp_cof_q[3];
				csel[1] = exp_cof_q[4];
				csel[2] = exp_cof_q[5];
				nsel    = exp_num_q[1];
			end
			ROW2: begin
				csel[0] = exp_cof_q[6];
				csel[1] = exp_cof_q[7];
				csel[2] = exp_cof_q[8];
				nsel    = exp_num_q[2];
			end
			default: begin
				csel[0] = '0;
				csel[1] = '0;
				csel[2] = '0;
				nsel    = '0;
			end
		endcase
		for (int j = 0; j < 3; j++) begin
			cabs[j] = csel[j][CW-1] ? CW'(-csel[j]) : CW'(csel[j]);
		end
		nabs = nsel[DETW-1] ? DETW'(-nsel) : DETW'(nsel);
	end

	// row stage: numerator magnitudes, doubled for rounding
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s8 <= '0;
			for (int s = 0; s < DIV_LAT; s++) begin
				meta_s[s] <= '0;
			end
		end else if (be) begin
			meta_s8.valid    <= exp_valid_q;
			meta_s8.row      <= exp_cnt_q;
			meta_s8.singular <= exp_sing_q;
			meta_s[0] <= meta_s8;
			for (int s = 1; s < DIV_LAT; s++) begin
				meta_s[s] <= meta_s[s-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (be) begin
			for (int j = 0; j < 3; j++) begin
				num2_s8[j] <= NW'(cabs[j]) << (2 * FRAC_BITS + 1);
				neg_s8[j]  <= csel[j][CW-1] ^ exp_dneg_q;
			end
			num2_s8[3] <= NW'(nabs) << (FRAC_BITS + 1);
			neg_s8[3]  <= ~nsel[DETW-1] ^ exp_dneg_q;
			dabs_s8    <= exp_dabs_q;
		end
	end

	for (genvar l = 0; l < NLANE; l++) begin : g_lane
		ami_div u_div (
			.clk  (clk),
			.en   (be),
			.num2 (num2_s8[l]),
			.den  (dabs_s8),
			.neg  (neg_s8[l]),
			.quo  (quo[l]),
			.sat  (lsat[l])
		);
	end

	assign mt = meta_s[DIV_LAT-1];

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_valid_q <= 1'b0;
		end else if (be) begin
			inv_valid_q <= mt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (be) begin
			inv_row_q  <= mt.row;
			inv_sing_q <= mt.singular;
			inv_last_q <= mt.row == ROW_LAST;
			if (mt.singular) begin
				inv_c_q[0] <= (mt.row == ROW0) ? FIX_ONE : FIX_ZERO;
				inv_c_q[1] <= (mt.row == ROW1) ? FIX_ONE : FIX_ZERO;
				inv_c_q[2] <= (mt.row == ROW2) ? FIX_ONE : FIX_ZERO;
				inv_c_q[3] <= FIX_ZERO;
				inv_sat_q  <= 1'b0;
			end else begin
				for (int l = 0; l < NLANE; l++) begin
					inv_c_q[l] <= quo[l];
				end
				inv_sat_q <= lsat[0] | lsat[1] | lsat[2] | lsat[3];
			end
		end
	end

	assign inv.valid     = inv_valid_q;
	assign inv.row_index = inv_row_q;
	assign inv.inv_c0    = inv_c_q[0];
	assign inv.inv_c1    = inv_c_q[1];
	assign inv.inv_c2    = inv_c_q[2];
	assign inv.inv_c3    = inv_c_q[3];
	assign inv.singular  = inv_sing_q;
	assign inv.saturated = inv_sat_q;
	assign inv.last_row  = inv_last_q;

`ifndef SYNTH
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		exp_valid_q |-> (exp_cnt_q == ROW0 || exp_cnt_q == ROW1 || exp_cnt_q == ROW2))
		else $error("row counter out of range");

	a_exp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(exp_valid_q && be && (exp_cnt_q != ROW_LAST)) |=> exp_valid_q)
		else $error("matrix dropped before its last row");

	a_sing_nosat: assert property (@(posedge clk) disable iff (!arst_n)
		(inv.valid && inv.singular) |-> !inv.saturated)
		else $error("identity word flagged saturated");

	a_in_block: assert property (@(posedge clk) disable iff (!arst_n)
		(exp_valid_q && !be) |-> !mat.ready || !fr.valid)
		else $error("front advanced into a stalled expander");
`endif
endmodule

FILE: tb/tb_top.sv
// self-checking testbench for the affine 3x4 matrix inverse: directed and random matrices
`timescale 1ns / 1ps
module tb_top;
	import ami_pkg::*;

	typedef logic signed [159:0] big_t;
	typedef struct {
		data_t e[12];
	} matrix_t;
	typedef struct {
		row_t  idx;
		data_t c[4];
		logic  sing;
		logic  sat;
		logic  last;
	} inv_row_t;
	typedef enum int {K_PRED, K_SING, K_IDENT} kind_t;
	typedef struct {
		kind_t   kind;
		matrix_t m;
	} vec_t;

	localparam data_t DMAX = 32'sh7fffffff;
	localparam data_t DMIN = 32'sh80000000;
	localparam int QUIET_LIMIT = 3000;
	localparam int DRAIN = 80;

	logic clk;
	logic arst_n;
	ami_cfg_if cfg_ch();
	ami_mat_if mat_ch();
	ami_out_if inv_ch();

	affine_matrix_inverse DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch),
		.mat(mat_ch),
		.inv(inv_ch)
	);

	inv_row_t expected_rows[$];
	vec_t table_v[$];
	logic [THR_WIDTH-1:0] thr_model;
	logic quiet;
	int mismatches, rows_seen, sing_rows, sat_rows, mats_sent, quiet_cycles, ready_hold;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic queue_row(inv_row_t r);
		expected_rows.insert(expected_rows.size(), r);
	endtask

	task automatic add_vec(kind_t k, matrix_t m);
		vec_t v;
		v.kind = k;
		v.m = m;
		table_v.insert(table_v.size(), v);
	endtask

	function automatic big_t div_near(big_t n, big_t d);
		big_t an, ad, q, r;
		an = (n < 0) ? -n : n;
		ad = (d < 0) ? -d : d;
		q = an / ad;
		r = an % ad;
		if (2 * r >= ad)
			q = q + 1;
		return ((n < 0) != (d < 0)) ? -q : q;
	endfunction

	function automatic data_t clip_q(big_t v, ref logic sat);
		if (v > big_t'(DMAX)) begin
			sat = 1'b1;
			return DMAX;
		end
		if (v < big_t'(DMIN)) begin
			sat = 1'b1;
			return DMIN;
		end
		return data_t'(v);
	endfunction

	// queues the three rows of the inverse
	task automatic predict_inverse(matrix_t m);
		big_t a[3][3], t[3], c[3][3], det, mag, thr, n;
		inv_row_t r;
		logic singular;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++)
				a[i][j] = m.e[i*3+j];
			t[i] = m.e[9+i];
		end
		c[0][0] = a[1][1]*a[2][2] - a[1][2]*a[2][1];
		c[0][1] = a[0][2]*a[2][1] - a[0][1]*a[2][2];
		c[0][2] = a[0][1]*a[1][2] - a[0][2]*a[1][1];
		c[1][0] = a[1][2]*a[2][0] - a[1][0]*a[2][2];
		c[1][1] = a[0][0]*a[2][2] - a[0][2]*a[2][0];
		c[1][2] = a[0][2]*a[1][0] - a[0][0]*a[1][2];
		c[2][0] = a[1][0]*a[2][1] - a[1][1]*a[2][0];
		c[2][1] = a[0][1]*a[2][0] - a[0][0]*a[2][1];
		c[2][2] = a[0][0]*a[1][1] - a[0][1]*a[1][0];
		det = a[0][0]*c[0][0] + a[0][1]*c[1][0] + a[0][2]*c[2][0];
		mag = ((det < 0) ? -det : det) >>> (2 * FRAC_BITS);
		thr = {129'd0, thr_model};
		singular = (mag <= thr);
		for (int i = 0; i < 3; i++) begin
			r.idx = row_t'(i);
			r.sing = singular;
			r.sat = 1'b0;
			r.last = (r.idx == ROW_LAST);
			if (singular) begin
				for (int j = 0; j < 3; j++)
					r.c[j] = (i == j) ? FIX_ONE : FIX_ZERO;
				r.c[3] = FIX_ZERO;
			end else begin
				n = 0;
				for (int j = 0; j < 3; j++) begin
					r.c[j] = clip_q(div_near(c[i][j] <<< (2 * FRAC_BITS), det), r.sat);
					n = n + c[i][j] * t[j];
				end
				r.c[3] = clip_q(div_near((-n) <<< FRAC_BITS, det), r.sat);
			end
			queue_row(r);
		end
	endtask

	// rows read straight off the matrix
	task automatic push_typed(kind_t k, matrix_t m);
		inv_row_t r;
		for (int i = 0; i < 3; i++) begin
			r.idx = row_t'(i);
			r.sing = (k == K_SING);
			r.sat = 1'b0;
			r.last = (r.idx == ROW_LAST);
			for (int j = 0; j < 3; j++)
				r.c[j] = (i == j) ? FIX_ONE : FIX_ZERO;
			r.c[3] = (k == K_SING) ? FIX_ZERO : -m.e[9+i];
			queue_row(r);
		end
	endtask

	task automatic send_matrix(kind_t k, matrix_t m);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			mat_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		mat_ch.valid <= 1'b1;
		{mat_ch.m00, mat_ch.m01, mat_ch.m02, mat_ch.m10, mat_ch.m11, mat_ch.m12,
			mat_ch.m20, mat_ch.m21, mat_ch.m22, mat_ch.tx, mat_ch.ty, mat_ch.tz} <=
			{m.e[0], m.e[1], m.e[2], m.e[3], m.e[4], m.e[5], m.e[6], m.e[7], m.e[8],
			m.e[9], m.e[10], m.e[11]};
		do @(posedge clk); while (!mat_ch.ready);
		if (k == K_PRED)
			predict_inverse(m);
		else
			push_typed(k, m);
		mats_sent++;
	endtask

	task automatic wait_idle();
		mat_ch.valid <= 1'b0;
		while (expected_rows.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_threshold(logic [THR_WIDTH-1:0] v);
		cfg_ch.valid <= 1'b1;
		cfg_ch.singular_threshold <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		thr_model = v;
	endtask

	function automatic data_t rnd_range(int lo, int hi);
		return data_t'($urandom_range(0, hi - lo) + lo);
	endfunction

	function automatic matrix_t random_matrix();
		matrix_t m;
		int kind;
		kind = $urandom_range(0, 9);
		for (int i = 0; i < 12; i++)
			m.e[i] = data_t'($urandom());
		case (kind)
			0, 1, 2, 3, 4: begin
				for (int i = 0; i < 9; i++)
					m.e[i] = rnd_range(-32768, 32768);
				for (int i = 0; i < 3; i++)
					m.e[i*4] = (($urandom_range(0, 1) != 0) ? 1 : -1) *
						rnd_range(16384, 262144);
				for (int i = 9; i < 12; i++)
					m.e[i] = rnd_range(-(1 << 24), 1 << 24);
			end
			5: begin
				for (int i = 0; i < 9; i++)
					m.e[i] = data_t'($signed(16'($urandom())));
			end
			6: begin
				for (int j = 0; j < 3; j++)
					m.e[6+j] = m.e[j];
			end
			7: begin
				for (int i = 0; i < 9; i++)
					m.e[i] = (i % 4 == 0) ? rnd_range(2048, 65536) : FIX_ZERO;
			end
			8: begin
				for (int i = 0; i < 12; i++)
					m.e[i] = ($urandom_range(0, 1) != 0) ? DMAX : DMIN;
			end
			default: ;
		endcase
		return m;
	endfunction

	function automatic matrix_t diag(data_t d0, data_t d1, data_t d2, data_t x, data_t y,
		data_t z);
		matrix_t m;
		foreach (m.e[i])
			m.e[i] = FIX_ZERO;
		m.e[0] = d0;
		m.e[4] = d1;
		m.e[8] = d2;
		m.e[9] = x;
		m.e[10] = y;
		m.e[11] = z;
		return m;
	endfunction

	function automatic matrix_t fill(data_t v);
		matrix_t m;
		foreach (m.e[i])
			m.e[i] = v;
		return m;
	endfunction

	// sink side
	always @(posedge clk) begin
		if (!arst_n) begin
			inv_ch.ready <= 1'b0;
			ready_hold <= 0;
		end else if (!quiet && ready_hold == 0 && $urandom_range(0, 7) == 0) begin
			inv_ch.ready <= 1'b0;
			ready_hold <= $urandom_range(0, 10);
		end else if (!quiet && ready_hold != 0) begin
			inv_ch.ready <= 1'b0;
			ready_hold <= ready_hold - 1;
		end else
			inv_ch.ready <= 1'b1;
	end

	// checker
	always @(posedge clk) begin
		inv_row_t x;
		logic bad;
		if (arst_n && inv_ch.valid && inv_ch.ready) begin
			rows_seen++;
			if (inv_ch.singular)
				sing_rows++;
			if (inv_ch.saturated)
				sat_rows++;
			if (expected_rows.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("row word %0d with none expected", inv_ch.row_index);
			end else begin
				x = expected_rows.pop_front();
				bad = inv_ch.row_index !== x.idx || inv_ch.inv_c0 !== x.c[0] ||
					inv_ch.inv_c1 !== x.c[1] || inv_ch.inv_c2 !== x.c[2] ||
					inv_ch.inv_c3 !== x.c[3] || inv_ch.singular !== x.sing ||
					inv_ch.saturated !== x.sat || inv_ch.last_row !== x.last;
				if (bad) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch exp row %0d %h %h %h %h s%b c%b l%b",
							x.idx, x.c[0], x.c[1], x.c[2], x.c[3], x.sing, x.sat, x.last);
						$display("         got row %0d %h %h %h %h s%b c%b l%b",
							inv_ch.row_index, inv_ch.inv_c0, inv_ch.inv_c1, inv_ch.inv_c2,
							inv_ch.inv_c3, inv_ch.singular, inv_ch.saturated,
							inv_ch.last_row);
					end
				end
			end
		end
	end

	// watchdog on cycles without any word moving
	always @(posedge clk) begin
		if ((mat_ch.valid && mat_ch.ready) || (inv_ch.valid && inv_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("affine_matrix_inverse verification failed");
			$finish;
		end
	end

	initial begin
		vec_t v;
		matrix_t m;
		int counts[5];
		logic [THR_WIDTH-1:0] thrs[5];
		arst_n = 1'b0;
		quiet = 1'b0;
		thr_model = '0;
		mismatches = 0;
		rows_seen = 0;
		sing_rows = 0;
		sat_rows = 0;
		mats_sent = 0;
		quiet_cycles = 0;
		ready_hold = 0;
		mat_ch.valid = 1'b0;
		{mat_ch.m00, mat_ch.m01, mat_ch.m02, mat_ch.m10, mat_ch.m11, mat_ch.m12,
			mat_ch.m20, mat_ch.m21, mat_ch.m22, mat_ch.tx, mat_ch.ty, mat_ch.tz} = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.singular_threshold = '0;
		inv_ch.ready = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_vec(K_IDENT, diag(FIX_ONE, FIX_ONE, FIX_ONE, 0, 0, 0));
		add_vec(K_IDENT, diag(FIX_ONE, FIX_ONE, FIX_ONE, 32'sh10000,
			32'sh20000, -32'sh30000));
		add_vec(K_IDENT, diag(FIX_ONE, FIX_ONE, FIX_ONE, DMAX, DMIN + 1, 1));
		add_vec(K_SING, fill(FIX_ZERO));
		add_vec(K_SING, diag(1, 1, 1, DMAX, DMIN, 5));
		add_vec(K_SING, fill(DMAX));
		add_vec(K_SING, fill(DMIN));
		add_vec(K_PRED, diag(DMIN, DMIN, DMIN, DMAX, DMIN, DMAX));
		add_vec(K_PRED, diag(DMAX, DMAX, DMAX, DMIN, DMAX, DMIN));
		add_vec(K_PRED, diag(32'sh8000, 32'sh8000, 32'sh8000, 7, -7, 32'sh10000));
		add_vec(K_PRED, diag(32'sh30000, 32'sh30000, -32'sh30000, 1, 2, 3));
		add_vec(K_PRED, diag(32'sh1000, 32'sh1000, 32'sh1000, DMAX, DMIN, 0));
		add_vec(K_PRED, diag(32'sh1000, 32'sh1000, 32'sh100000, 1, 1, 1));
		m = diag(FIX_ONE, FIX_ONE, FIX_ONE, 32'sh10000, 0, 0);
		m.e[0] = FIX_ZERO;
		m.e[1] = FIX_ONE;
		m.e[3] = FIX_ONE;
		m.e[4] = FIX_ZERO;
		add_vec(K_PRED, m);
		add_vec(K_PRED, fill(32'sh55555555));
		for (int i = 0; i < 4; i++) begin
			foreach (m.e[j])
				m.e[j] = data_t'($urandom());
			add_vec(K_PRED, m);
		end
		foreach (table_v[i]) begin
			v = table_v[i];
			send_matrix(v.kind, v.m);
		end

		thrs = '{31'd0, 31'h7fffffff, 31'd0, 31'd0, 31'd0};
		thrs[2] = 31'($urandom_range(0, 255));
		thrs[3] = 31'($urandom());
		counts = '{110, 40, 70, 30, 60};
		for (int p = 0; p < 5; p++) begin
			wait_idle();
			write_threshold(thrs[p]);
			if (p == 4)
				quiet = 1'b1;
			repeat (counts[p]) send_matrix(K_PRED, random_matrix());
		end
		wait_idle();

		$display("%0d matrices over five threshold settings, %0d rows checked", mats_sent,
			rows_seen);
		$display("%0d singular rows, %0d clipped rows, %0d mismatches", sing_rows, sat_rows,
			mismatches);
		if (mismatches == 0 && expected_rows.size() == 0)
			$display("affine_matrix_inverse verification clean");
		else
			$display("affine_matrix_inverse verification failed");
		$finish;
	end
endmodule
